[src/eocd_pkg.sv]
// Shared types, codes and default sizes for the even/odd column destripe block.
package eocd_pkg;

  localparam int PIXEL_WIDTH_DEF = 32;
  localparam int COUNT_WIDTH_DEF = 24;

  localparam int IN_PIX_W = 32;
  localparam int COLUMN_W = 13;
  localparam int CMD_W    = 2;
  localparam int ST_W     = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_CLEAR   = 2'd0,
    CMD_ACCUM   = 2'd1,
    CMD_COMPUTE = 2'd2,
    CMD_APPLY   = 2'd3
  } cmd_t;

  typedef enum logic [ST_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_SAT   = 2'd2
  } status_t;

  typedef struct packed {
    logic accept;
    logic div_start;
    logic div_sel_odd;
    logic latch_even;
    logic finish;
  } ctrl_cmd_t;

  typedef struct packed {
    logic cnt_zero;
    logic out_valid;
    logic div_done;
  } dp_stat_t;

endpackage

[src/eocd_div.sv]
// Restoring divider, one quotient bit per cycle, truncating toward zero.
module eocd_div import eocd_pkg::*; #(
  parameter int NUM_W = PIXEL_WIDTH_DEF + COUNT_WIDTH_DEF + 1,
  parameter int DEN_W = COUNT_WIDTH_DEF + 1
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic signed [NUM_W-1:0] dividend,
  input  logic        [DEN_W-1:0] divisor,
  output logic                    done,
  output logic signed [NUM_W:0]   quotient
);

  localparam int CNT_BITS = $clog2(NUM_W + 1);

  logic                busy_r;
  logic                done_r;
  logic [CNT_BITS-1:0] cnt_r;
  logic [DEN_W-1:0]    rem_r;
  logic [NUM_W-1:0]    quo_r;
  logic [DEN_W-1:0]    den_r;
  logic                neg_r;

  logic [NUM_W-1:0] mag;
  logic [DEN_W:0]   trial;
  logic [DEN_W:0]   diff;
  logic             fits;
  logic [NUM_W:0]   q_ext;

  assign mag   = dividend[NUM_W-1] ? (~dividend + 1'b1) : dividend;
  assign trial = {rem_r, quo_r[NUM_W-1]};
  assign diff  = trial - {1'b0, den_r};
  assign fits  = trial >= {1'b0, den_r};
  assign q_ext = {1'b0, quo_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= CNT_BITS'(NUM_W);
    end else if (busy_r) begin
      cnt_r <= cnt_r - 1'b1;
      if (cnt_r == CNT_BITS'(1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end else begin
      done_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= mag;
      den_r <= divisor;
      neg_r <= dividend[NUM_W-1];
    end else if (busy_r) begin
      rem_r <= fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      quo_r <= {quo_r[NUM_W-2:0], fits};
    end
  end

  assign done     = done_r;
  assign quotient = neg_r ? (~q_ext + 1'b1) : q_ext;

endmodule

[src/eocd_dp.sv]
// Datapath: group sums and counts, offset, apply arithmetic and output register.
module eocd_dp import eocd_pkg::*; #(
  parameter int PIXEL_WIDTH = PIXEL_WIDTH_DEF,
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  ctrl_cmd_t                  cmd,
  output dp_stat_t                   st,
  input  logic [CMD_W-1:0]           in_command,
  input  logic signed [IN_PIX_W-1:0] in_pixel_value,
  input  logic                       in_pixel_valid,
  input  logic [COLUMN_W-1:0]        in_column,
  input  logic                       out_stall,
  output logic                       out_valid,
  output logic signed [IN_PIX_W-1:0] out_pixel_out,
  output logic [ST_W-1:0]            out_status
);

  localparam int SUM_W = (PIXEL_WIDTH + COUNT_WIDTH + 1 > 64) ? 64
                                                              : PIXEL_WIDTH + COUNT_WIDTH + 1;
  localparam int CNT_W = COUNT_WIDTH + 1;
  localparam int QUO_W = SUM_W + 1;
  localparam int LW    = (SUM_W + 2 > IN_PIX_W + 2) ? SUM_W + 2 : IN_PIX_W + 2;

  localparam logic signed [LW-1:0] PMAX = {{(LW-PIXEL_WIDTH+1){1'b0}}, {(PIXEL_WIDTH-1){1'b1}}};
  localparam logic signed [LW-1:0] PMIN = {{(LW-PIXEL_WIDTH+1){1'b1}}, {(PIXEL_WIDTH-1){1'b0}}};
  localparam logic [SUM_W-1:0] SMAX = {1'b0, {(SUM_W-1){1'b1}}};
  localparam logic [SUM_W-1:0] SMIN = {1'b1, {(SUM_W-1){1'b0}}};

  logic signed [SUM_W-1:0]       sum_e_r, sum_o_r;
  logic        [CNT_W-1:0]       cnt_e_r, cnt_o_r;
  logic signed [PIXEL_WIDTH-1:0] offset_r;
  logic signed [QUO_W-1:0]       q_even_r;
  logic                          out_valid_r;
  logic signed [IN_PIX_W-1:0]    out_pixel_r;
  logic [ST_W-1:0]               out_status_r;

  logic signed [LW-1:0] pix_ext, pix_c, off_ext, app_sum, app_c;
  logic signed [LW-1:0] q_diff, q_half, new_off, res;
  logic                 app_sat, odd_grp, cnt_full, acc_en, clear, load;
  logic [SUM_W-1:0]     sum_sel, sum_acc;
  logic [SUM_W:0]       sum_add;
  logic [CNT_W-1:0]     cnt_sel;
  logic [ST_W-1:0]      res_st;
  logic signed [QUO_W-1:0] div_q;
  logic                 div_done;

  assign pix_ext = {{(LW-IN_PIX_W){in_pixel_value[IN_PIX_W-1]}}, in_pixel_value};
  assign pix_c   = (pix_ext > PMAX) ? PMAX : ((pix_ext < PMIN) ? PMIN : pix_ext);
  assign off_ext = {{(LW-PIXEL_WIDTH){offset_r[PIXEL_WIDTH-1]}}, offset_r};
  assign odd_grp = ~in_column[0];

  assign app_sum = odd_grp ? (pix_c + off_ext) : (pix_c - off_ext);
  assign app_sat = (app_sum > PMAX) || (app_sum < PMIN);
  assign app_c   = (app_sum > PMAX) ? PMAX : ((app_sum < PMIN) ? PMIN : app_sum);

  assign sum_sel  = odd_grp ? sum_o_r : sum_e_r;
  assign cnt_sel  = odd_grp ? cnt_o_r : cnt_e_r;
  assign cnt_full = cnt_sel[CNT_W-1];
  assign sum_add  = {sum_sel[SUM_W-1], sum_sel} + pix_c[SUM_W:0];
  assign sum_acc  = (sum_add[SUM_W] != sum_add[SUM_W-1]) ? (sum_add[SUM_W] ? SMIN : SMAX)
                                                         : sum_add[SUM_W-1:0];

  assign clear  = cmd.accept && (in_command == CMD_CLEAR);
  assign acc_en = cmd.accept && (in_command == CMD_ACCUM) && in_pixel_valid && !cnt_full;
  assign load   = cmd.finish || (cmd.accept && !cmd.div_start);

  assign q_diff  = {{(LW-QUO_W){q_even_r[QUO_W-1]}}, q_even_r}
                 - {{(LW-QUO_W){div_q[QUO_W-1]}}, div_q};
  assign q_half  = q_diff >>> 1;
  assign new_off = (q_half > PMAX) ? PMAX : ((q_half < PMIN) ? PMIN : q_half);

  eocd_div #(
    .NUM_W (SUM_W),
    .DEN_W (CNT_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (cmd.div_sel_odd ? sum_o_r : sum_e_r),
    .divisor  (cmd.div_sel_odd ? cnt_o_r : cnt_e_r),
    .done     (div_done),
    .quotient (div_q)
  );

  always_comb begin
    res    = '0;
    res_st = ST_OK;
    if (cmd.finish) begin
      res = new_off;
    end else begin
      case (cmd_t'(in_command))
        CMD_CLEAR, CMD_ACCUM: begin
          res = '0;
        end
        CMD_COMPUTE: begin
          res    = off_ext;
          res_st = ST_EMPTY;
        end
        CMD_APPLY: begin
          if (in_pixel_valid) begin
            res    = app_c;
            res_st = app_sat ? ST_SAT : ST_OK;
          end else begin
            res = pix_c;
          end
        end
        default: begin
          res = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_e_r     <= '0;
      sum_o_r     <= '0;
      cnt_e_r     <= '0;
      cnt_o_r     <= '0;
      offset_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (clear) begin
        sum_e_r <= '0;
        sum_o_r <= '0;
        cnt_e_r <= '0;
        cnt_o_r <= '0;
      end else if (acc_en) begin
        if (odd_grp) begin
          sum_o_r <= sum_acc;
          cnt_o_r <= cnt_o_r + 1'b1;
        end else begin
          sum_e_r <= sum_acc;
          cnt_e_r <= cnt_e_r + 1'b1;
        end
      end
      if (cmd.finish) begin
        offset_r <= new_off[PIXEL_WIDTH-1:0];
      end
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch_even) begin
      q_even_r <= div_q;
    end
    if (load) begin
      out_pixel_r  <= res[IN_PIX_W-1:0];
      out_status_r <= res_st;
    end
  end

  assign st.cnt_zero  = (cnt_e_r == '0) || (cnt_o_r == '0);
  assign st.out_valid = out_valid_r;
  assign st.div_done  = div_done;

  assign out_valid     = out_valid_r;
  assign out_pixel_out = out_pixel_r;
  assign out_status    = out_status_r;

endmodule

[src/eocd_ctrl.sv]
// Controller: input handshake and sequencing of the two mean divisions.
module eocd_ctrl import eocd_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic [CMD_W-1:0] in_command,
  input  logic             out_stall,
  input  dp_stat_t         st,
  output ctrl_cmd_t        cmd,
  output logic             in_stall
);

  typedef enum logic [3:0] {
    S_IDLE     = 4'b0001,
    S_DIV_EVEN = 4'b0010,
    S_DIV_ODD  = 4'b0100,
    S_FINISH   = 4'b1000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_free;

  assign out_free = !st.out_valid || !out_stall;
  assign in_stall = (state_r != S_IDLE) || !out_free;

  always_comb begin
    state_nxt       = state_r;
    cmd             = '0;
    cmd.accept      = in_valid && !in_stall;
    case (state_r)
      S_IDLE: begin
        if (cmd.accept && (in_command == CMD_COMPUTE) && !st.cnt_zero) begin
          cmd.div_start = 1'b1;
          state_nxt     = S_DIV_EVEN;
        end
      end
      S_DIV_EVEN: begin
        if (st.div_done) begin
          cmd.latch_even  = 1'b1;
          cmd.div_start   = 1'b1;
          cmd.div_sel_odd = 1'b1;
          state_nxt       = S_DIV_ODD;
        end
      end
      S_DIV_ODD: begin
        if (st.div_done) begin
          state_nxt = S_FINISH;
        end
      end
      S_FINISH: begin
        if (out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

[src/even_odd_column_destripe.sv]
// Even/odd column destripe: group statistics, offset compute and offset apply.
//
// Input channel (in_valid/in_stall) carries one command word: clear, accumulate,
// compute or apply, with a pixel, its valid flag and its column. Output channel
// (out_valid/out_stall) returns exactly one word per input word: the corrected
// pixel on apply (the clamped pixel if its valid flag is low), the offset on
// compute, zero otherwise, plus a status code. For clear, accumulate and apply
// the result sits in the output register in the cycle after acceptance, and a
// new word is accepted every cycle while the output is taken. Compute runs two
// signed divisions of the group sums by the group counts on one shared restoring
// divider, one quotient bit per cycle: the even one, then the odd one, then a
// finish state registers the offset. No word is accepted while a compute runs.
// A compute with an empty group answers in the cycle after acceptance with the
// old offset. Reset clears sums, counts and offset. When the receiver stalls,
// the output word holds and in_stall rises until it is taken.
module even_odd_column_destripe import eocd_pkg::*; #(
  parameter int PIXEL_WIDTH = PIXEL_WIDTH_DEF,
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [CMD_W-1:0]           in_command,
  input  logic signed [IN_PIX_W-1:0] in_pixel_value,
  input  logic                       in_pixel_valid,
  input  logic [COLUMN_W-1:0]        in_column,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic signed [IN_PIX_W-1:0] out_pixel_out,
  output logic [ST_W-1:0]            out_status
);

  ctrl_cmd_t cmd;
  dp_stat_t  st;

  eocd_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_command (in_command),
    .out_stall  (out_stall),
    .st         (st),
    .cmd        (cmd),
    .in_stall   (in_stall)
  );

  eocd_dp #(
    .PIXEL_WIDTH (PIXEL_WIDTH),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .st             (st),
    .in_command     (in_command),
    .in_pixel_value (in_pixel_value),
    .in_pixel_valid (in_pixel_valid),
    .in_column      (in_column),
    .out_stall      (out_stall),
    .out_valid      (out_valid),
    .out_pixel_out  (out_pixel_out),
    .out_status     (out_status)
  );

  a_rise_has_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> ($past(in_valid && !in_stall) || $past(cmd.finish)))
    else $error("output word appeared without an accepted word or finished compute");

  a_finish_out_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |-> (!out_valid || !out_stall))
    else $error("compute result would overwrite a stalled output word");

  a_no_accept_div_done: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |-> !st.div_done)
    else $error("word accepted while a division result is pending");

endmodule

[tb/sv/tb_even_odd_column_destripe.sv]
// Testbench for even_odd_column_destripe: directed, back-pressure and random frame tests.
module tb_even_odd_column_destripe;
  import eocd_pkg::*;

  localparam longint PIX_HI = (64'sd1 <<< (PIXEL_WIDTH_DEF - 1)) - 64'sd1;
  localparam longint PIX_LO = -PIX_HI - 64'sd1;
  localparam longint unsigned CNT_CAP = 64'd1 << COUNT_WIDTH_DEF;
  localparam int RANDOM_WORDS = 580;

  typedef struct {
    logic signed [IN_PIX_W-1:0] pix;
    status_t                    st;
  } dest_word_t;

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       in_valid = 1'b0;
  logic                       in_stall;
  logic [CMD_W-1:0]           in_command = CMD_CLEAR;
  logic signed [IN_PIX_W-1:0] in_pixel_value = '0;
  logic                       in_pixel_valid = 1'b0;
  logic [COLUMN_W-1:0]        in_column = '0;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  logic signed [IN_PIX_W-1:0] out_pixel_out;
  logic [ST_W-1:0]            out_status;

  dest_word_t expected_q[$];

  longint          even_sum = 0;
  longint          odd_sum = 0;
  longint unsigned even_cnt = 0;
  longint unsigned odd_cnt = 0;
  longint          stripe_ofs = 0;

  int err_cnt = 0;
  int words_sent = 0;
  int stall_pct = 0;
  int gap_max = 0;
  int burst_left = 0;
  int hold_req = 0;
  int run_left = 0;

  even_odd_column_destripe dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_command     (in_command),
    .in_pixel_value (in_pixel_value),
    .in_pixel_valid (in_pixel_valid),
    .in_column      (in_column),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_pixel_out  (out_pixel_out),
    .out_status     (out_status)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("FAILURE");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    err_cnt++;
    if (err_cnt <= 100) begin
      $display("MISMATCH at %0t: %s", $realtime, msg);
    end
  endtask

  function automatic longint clamp_pixel(input longint v, output bit hit);
    hit = 1'b0;
    if (v > PIX_HI) begin
      hit = 1'b1;
      return PIX_HI;
    end
    if (v < PIX_LO) begin
      hit = 1'b1;
      return PIX_LO;
    end
    return v;
  endfunction

  function automatic longint add_sat64(input longint a, input longint b);
    longint s;
    s = a + b;
    if (a[63] == b[63] && s[63] != a[63]) begin
      return a[63] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    end
    return s;
  endfunction

  task automatic add_to_group(ref longint sum, ref longint unsigned cnt, input longint v);
    if (cnt >= CNT_CAP) return;
    sum = add_sat64(sum, v);
    cnt++;
  endtask

  task automatic predict_destripe(input cmd_t cmd, input logic signed [IN_PIX_W-1:0] raw,
                                  input logic pv, input logic [COLUMN_W-1:0] col);
    longint     pix;
    longint     mean_e;
    longint     mean_o;
    bit         hit;
    bit         odd_grp;
    dest_word_t w;
    pix = clamp_pixel(longint'(raw), hit);
    odd_grp = (col[0] == 1'b0);
    w.pix = '0;
    w.st = ST_OK;
    case (cmd)
      CMD_CLEAR: begin
        even_sum = 0;
        odd_sum = 0;
        even_cnt = 0;
        odd_cnt = 0;
      end
      CMD_ACCUM: begin
        if (pv && odd_grp) begin
          add_to_group(odd_sum, odd_cnt, pix);
        end else if (pv) begin
          add_to_group(even_sum, even_cnt, pix);
        end
      end
      CMD_COMPUTE: begin
        if (even_cnt == 0 || odd_cnt == 0) begin
          w.st = ST_EMPTY;
        end else begin
          mean_e = even_sum / longint'(even_cnt);
          mean_o = odd_sum / longint'(odd_cnt);
          stripe_ofs = clamp_pixel((mean_e - mean_o) >>> 1, hit);
        end
        w.pix = IN_PIX_W'(stripe_ofs);
      end
      default: begin
        if (pv) begin
          w.pix = IN_PIX_W'(clamp_pixel(odd_grp ? pix + stripe_ofs : pix - stripe_ofs, hit));
          if (hit) w.st = ST_SAT;
        end else begin
          w.pix = IN_PIX_W'(pix);
        end
      end
    endcase
    expected_q.push_back(w);
  endtask

  task automatic pause_input(input int n);
    in_valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_q.size() != 0) @(posedge clk);
  endtask

  task automatic send_word(input cmd_t cmd, input logic signed [IN_PIX_W-1:0] pix,
                           input logic pv, input logic [COLUMN_W-1:0] col);
    in_valid <= 1'b1;
    in_command <= cmd;
    in_pixel_value <= pix;
    in_pixel_valid <= pv;
    in_column <= col;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    predict_destripe(cmd, pix, pv, col);
    words_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else if (gap_max > 0) begin
      pause_input($urandom_range(1, gap_max));
      burst_left = $urandom_range(0, 15);
    end
  endtask

  function automatic logic signed [IN_PIX_W-1:0] rand_pixel();
    case ($urandom_range(0, 5))
      0: return $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
      1, 2: return 32'($urandom_range(0, 131071)) - 32'sd65536;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [COLUMN_W-1:0] rand_column();
    return COLUMN_W'($urandom_range(0, (1 << COLUMN_W) - 1));
  endfunction

  // receive side: long hold when asked, else random stall runs
  initial begin
    int n;
    forever begin
      @(posedge clk);
      if (!rst_n) begin
        out_stall <= 1'b0;
      end else if (hold_req > 0) begin
        n = hold_req;
        hold_req = 0;
        out_stall <= 1'b1;
        repeat (n - 1) @(posedge clk);
      end else if (run_left > 0) begin
        run_left--;
      end else begin
        out_stall <= ($urandom_range(0, 99) < stall_pct);
        run_left = $urandom_range(0, 3);
      end
    end
  end

  always @(posedge clk) begin
    dest_word_t w;
    if (rst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (expected_q.size() == 0) begin
        report_mismatch($sformatf("unexpected word pixel_out=%0d status=%0d",
                                  out_pixel_out, out_status));
      end else begin
        w = expected_q.pop_front();
        if (out_pixel_out !== w.pix) begin
          report_mismatch($sformatf("pixel_out %0d, expected %0d", out_pixel_out, w.pix));
        end
        if (out_status !== w.st) begin
          report_mismatch($sformatf("status %0d, expected %0d", out_status, w.st));
        end
      end
    end
  end

  task automatic test_directed();
    stall_pct = 30;
    gap_max = 3;
    send_word(CMD_COMPUTE, 32'sd0, 1'b1, 13'd0);
    send_word(CMD_ACCUM, 32'sh7FFF_FFFF, 1'b1, 13'd0);
    send_word(CMD_ACCUM, 32'sh8000_0000, 1'b1, 13'd8191);
    send_word(CMD_ACCUM, 32'sh1234_5678, 1'b0, 13'd1);
    send_word(CMD_COMPUTE, 32'sh7FFF_FFFF, 1'b0, 13'd8191);
    send_word(CMD_APPLY, 32'sh8000_0000, 1'b1, 13'd0);
    send_word(CMD_APPLY, 32'sh7FFF_FFFF, 1'b1, 13'd1);
    send_word(CMD_APPLY, 32'sh8000_0000, 1'b0, 13'd2);
    send_word(CMD_APPLY, 32'sd0, 1'b1, 13'd3);
    send_word(CMD_CLEAR, 32'shFFFF_FFFF, 1'b1, 13'd8191);
    send_word(CMD_COMPUTE, 32'sd0, 1'b1, 13'd0);
    send_word(CMD_ACCUM, 32'sd100, 1'b1, 13'd1);
    send_word(CMD_COMPUTE, 32'sd0, 1'b1, 13'd0);
    send_word(CMD_ACCUM, -32'sd7, 1'b1, 13'd8190);
    send_word(CMD_COMPUTE, 32'sd0, 1'b1, 13'd0);
    send_word(CMD_APPLY, 32'sd1000, 1'b1, 13'd4);
    send_word(CMD_APPLY, 32'sd1000, 1'b1, 13'd5);
    send_word(CMD_CLEAR, 32'sd0, 1'b0, 13'd0);
    send_word(CMD_ACCUM, -32'sd3, 1'b1, 13'd1);
    send_word(CMD_ACCUM, 32'sd0, 1'b1, 13'd3);
    send_word(CMD_ACCUM, 32'sd0, 1'b1, 13'd0);
    send_word(CMD_COMPUTE, 32'sd0, 1'b1, 13'd0);
    send_word(CMD_APPLY, 32'sd1000, 1'b1, 13'd6);
    send_word(CMD_APPLY, 32'sh7FFF_FFFF, 1'b0, 13'd8191);
    wait_drained();
  endtask

  task automatic test_backpressure();
    stall_pct = 0;
    gap_max = 0;
    hold_req = 200;
    send_word(CMD_CLEAR, rand_pixel(), 1'b1, rand_column());
    repeat (20) send_word(CMD_ACCUM, rand_pixel(), 1'b1, rand_column());
    send_word(CMD_COMPUTE, rand_pixel(), 1'b1, rand_column());
    repeat (20) send_word(CMD_APPLY, rand_pixel(), 1'b1, rand_column());
    wait_drained();
    repeat (4) send_word(CMD_APPLY, rand_pixel(), 1'($urandom_range(0, 1)), rand_column());
    wait_drained();
  endtask

  task automatic test_random_frames();
    int start;
    int n_acc;
    int n_app;
    start = words_sent;
    while (words_sent - start < RANDOM_WORDS) begin
      case ($urandom_range(0, 3))
        0: stall_pct = 0;
        1: stall_pct = 15;
        2: stall_pct = 50;
        default: stall_pct = 80;
      endcase
      gap_max = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(1, 8);
      if ($urandom_range(0, 4) == 0) begin
        repeat ($urandom_range(1, 4)) begin
          send_word(cmd_t'($urandom_range(0, 3)), rand_pixel(), 1'($urandom_range(0, 1)),
                    rand_column());
        end
      end
      send_word(CMD_CLEAR, rand_pixel(), 1'($urandom_range(0, 1)), rand_column());
      n_acc = $urandom_range(0, 30);
      repeat (n_acc) begin
        send_word(CMD_ACCUM, rand_pixel(), $urandom_range(0, 9) != 0, rand_column());
      end
      send_word(CMD_COMPUTE, rand_pixel(), 1'($urandom_range(0, 1)), rand_column());
      n_app = $urandom_range(1, 30);
      repeat (n_app) begin
        send_word(CMD_APPLY, rand_pixel(), $urandom_range(0, 7) != 0, rand_column());
      end
      if ($urandom_range(0, 3) == 0) wait_drained();
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_backpressure();
    test_random_frames();
    wait_drained();
    repeat (150) @(posedge clk);
    if (err_cnt == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
